// ----- design/pipc_pkg.sv -----
// ----------------------------------------------------------------------------
// pipc_pkg
// Shared widths, register map, reset values and helpers for the projective
// image point colorer.
// ----------------------------------------------------------------------------
package pipc_pkg;

  // Default size of the image store
  localparam int unsigned DEF_MAX_IMAGE_PIXELS = 1048576;
  // Largest image side that is used; larger register values saturate here
  localparam int unsigned MAX_IMAGE_SIDE = 1024;

  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 3 * COLOR_W;
  localparam int ADDR_W     = 20;
  localparam int EXT_ADDR_W = 25;
  localparam int SIDE_W     = 11;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  // Datapath widths
  localparam int S_W       = 34;
  localparam int NUM_W     = 64;
  localparam int DIV_STEPS = SIDE_W;
  localparam int DIV_LAT   = DIV_STEPS + 3;

  // Register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_POS_X  = 3'd0;
  localparam reg_idx_t REG_POS_Z  = 3'd1;
  localparam reg_idx_t REG_DIR_X  = 3'd2;
  localparam reg_idx_t REG_DIR_Z  = 3'd3;
  localparam reg_idx_t REG_INV_U  = 3'd4;
  localparam reg_idx_t REG_INV_V  = 3'd5;
  localparam reg_idx_t REG_WIDTH  = 3'd6;
  localparam reg_idx_t REG_HEIGHT = 3'd7;

  // Register reset values
  localparam logic signed [15:0] RST_POS_X  = 16'sd0;
  localparam logic signed [15:0] RST_POS_Z  = 16'sd0;
  localparam logic signed [15:0] RST_DIR_X  = 16'sd0;
  localparam logic signed [15:0] RST_DIR_Z  = -16'sd16384;
  localparam logic [15:0]        RST_INV_U  = 16'd5562;
  localparam logic [15:0]        RST_INV_V  = 16'd9889;
  localparam logic [SIDE_W-1:0]  RST_WIDTH  = 11'd1024;
  localparam logic [SIDE_W-1:0]  RST_HEIGHT = 11'd1024;

  // Sideband that travels with every request
  typedef struct packed {
    logic              is_wr;
    logic              live;
    logic [ADDR_W-1:0] addr;
    logic [RGB_W-1:0]  rgb;
  } side_t;

  // floor(c*2/5) as c*410 >> 10, exact for all 8-bit c
  function automatic logic [COLOR_W-1:0] dim_color(logic [COLOR_W-1:0] c);
    logic [16:0] p;
    p = 17'(c) * 17'd410;
    return COLOR_W'(p >> 10);
  endfunction

endpackage

// ----- design/pipc_if.sv -----
// ----------------------------------------------------------------------------
// pipc_if
// Valid/ready channels for point and pixel requests and for colored results.
// ----------------------------------------------------------------------------
interface pipc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   func;
  logic [pipc_pkg::ADDR_W-1:0]            pixel_address;
  logic signed [pipc_pkg::COORD_W-1:0]    point_x;
  logic signed [pipc_pkg::COORD_W-1:0]    point_y;
  logic signed [pipc_pkg::COORD_W-1:0]    point_z;
  logic                                   point_valid;
  logic [pipc_pkg::COLOR_W-1:0]           in_red;
  logic [pipc_pkg::COLOR_W-1:0]           in_green;
  logic [pipc_pkg::COLOR_W-1:0]           in_blue;

  modport source (
    output valid, func, pixel_address, point_x, point_y, point_z, point_valid,
           in_red, in_green, in_blue,
    input  ready
  );
  modport sink (
    input  valid, func, pixel_address, point_x, point_y, point_z, point_valid,
           in_red, in_green, in_blue,
    output ready
  );
endinterface

interface pipc_out_if;
  logic                         valid;
  logic                         ready;
  logic [pipc_pkg::COLOR_W-1:0] out_red;
  logic [pipc_pkg::COLOR_W-1:0] out_green;
  logic [pipc_pkg::COLOR_W-1:0] out_blue;
  logic                         hit;

  modport source (output valid, out_red, out_green, out_blue, hit, input ready);
  modport sink (input valid, out_red, out_green, out_blue, hit, output ready);
endinterface

// ----- design/pipc_round_div.sv -----
// ----------------------------------------------------------------------------
// pipc_round_div
// Pipelined rounded division num / (s*8192), half away from zero, one
// quotient bit per stage. Flags quotients that do not fit the bit count.
// ----------------------------------------------------------------------------
module pipc_round_div (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [pipc_pkg::NUM_W-1:0]     num_i,
  input  logic signed [pipc_pkg::S_W-1:0]       s_i,
  output logic [pipc_pkg::DIV_STEPS-1:0]        q_o,
  output logic                                  neg_o,
  output logic                                  ovf_o
);

  localparam int NW = pipc_pkg::NUM_W;
  localparam int SW = pipc_pkg::S_W;
  localparam int QB = pipc_pkg::DIV_STEPS;
  localparam int AD_W = SW + 13;
  localparam int D_W = AD_W + 1;

  // Stage 0: magnitudes and sign
  logic [NW-1:0]   an_q;
  logic [AD_W-1:0] ad_q;
  logic            neg0_q;
  logic [SW-1:0]   abs_s;
  logic [NW-1:0]   abs_n;

  always_comb begin
    abs_n = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    abs_s = s_i[SW-1] ? SW'(-s_i) : SW'(s_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_q   <= abs_n;
      ad_q   <= {abs_s, 13'b0};
      neg0_q <= num_i[NW-1] ^ s_i[SW-1];
    end
  end

  // Stage 1: rounding bias, N = 2|num| + |den|, D = 2|den|
  logic [NW-1:0]  r1_q;
  logic [D_W-1:0] d1_q;
  logic           neg1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q   <= {an_q[NW-2:0], 1'b0} + NW'(ad_q);
      d1_q   <= {ad_q, 1'b0};
      neg1_q <= neg0_q;
    end
  end

  // Stage 2: range check, then one restoring step per stage
  logic [NW-1:0]  r_q   [QB+1];
  logic [D_W-1:0] d_q   [QB+1];
  logic [QB-1:0]  q_q   [QB+1];
  logic           neg_q [QB+1];
  logic           ovf_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= r1_q;
      d_q[0]   <= d1_q;
      q_q[0]   <= '0;
      neg_q[0] <= neg1_q;
      ovf_q[0] <= r1_q >= (NW'(d1_q) << QB);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [NW-1:0] t;
    logic          ge;

    always_comb begin
      t  = NW'(d_q[k]) << (QB - 1 - k);
      ge = r_q[k] >= t;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? r_q[k] - t : r_q[k];
        d_q[k+1]   <= d_q[k];
        q_q[k+1]   <= q_q[k] | (QB'(ge) << (QB - 1 - k));
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign q_o   = q_q[QB];
  assign neg_o = neg_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

// ----- design/projective_image_point_colorer.sv -----
// Pipeline: a point request passes through 6 arithmetic stages, 14 divider
// stages, the address stage and the image read stage before its result appears.
// Throughput: one request per cycle; the whole pipeline advances together
// and holds while a result waits at the output.
// Reset: pipeline empty, registers to their defaults; image store content is
// undefined until written and is not cleared.
// ----------------------------------------------------------------------------
// projective_image_point_colorer
// Colors 3D points from a stored image as cast by a projector with a set
// position and heading; dims points that fall outside the image, have zero depth or are not valid.
// ----------------------------------------------------------------------------
module projective_image_point_colorer #(
  parameter int unsigned MAX_IMAGE_PIXELS = pipc_pkg::DEF_MAX_IMAGE_PIXELS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pipc_pkg::PADDR_W-1:0]   paddr,
  input  logic [pipc_pkg::PDATA_W-1:0]   pwdata,
  output logic [pipc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  pipc_in_if.sink                        in_i,
  pipc_out_if.source                     out_o
);

  localparam int AW = (MAX_IMAGE_PIXELS > 1) ? $clog2(MAX_IMAGE_PIXELS) : 1;
  localparam int EW = pipc_pkg::EXT_ADDR_W;
  localparam int SDW = pipc_pkg::SIDE_W;
  localparam int SW = pipc_pkg::S_W;
  localparam int NW = pipc_pkg::NUM_W;
  localparam int QB = pipc_pkg::DIV_STEPS;
  localparam int DL = pipc_pkg::DIV_LAT;
  localparam int CW = pipc_pkg::COLOR_W;
  localparam logic [EW-1:0] PIX_LIMIT = EW'(MAX_IMAGE_PIXELS);
  localparam logic [12:0] SIDE_LIMIT = 13'(pipc_pkg::MAX_IMAGE_SIDE);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] pos_x_q, pos_z_q, dir_x_q, dir_z_q;
  logic [15:0]        inv_u_q, inv_v_q;
  logic [SDW-1:0]     width_q, height_q;
  pipc_pkg::reg_idx_t reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= pipc_pkg::RST_POS_X;
      pos_z_q  <= pipc_pkg::RST_POS_Z;
      dir_x_q  <= pipc_pkg::RST_DIR_X;
      dir_z_q  <= pipc_pkg::RST_DIR_Z;
      inv_u_q  <= pipc_pkg::RST_INV_U;
      inv_v_q  <= pipc_pkg::RST_INV_V;
      width_q  <= pipc_pkg::RST_WIDTH;
      height_q <= pipc_pkg::RST_HEIGHT;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        pipc_pkg::REG_POS_X:  pos_x_q  <= pwdata[15:0];
        pipc_pkg::REG_POS_Z:  pos_z_q  <= pwdata[15:0];
        pipc_pkg::REG_DIR_X:  dir_x_q  <= pwdata[15:0];
        pipc_pkg::REG_DIR_Z:  dir_z_q  <= pwdata[15:0];
        pipc_pkg::REG_INV_U:  inv_u_q  <= pwdata[15:0];
        pipc_pkg::REG_INV_V:  inv_v_q  <= pwdata[15:0];
        pipc_pkg::REG_WIDTH:  width_q  <= pwdata[SDW-1:0];
        pipc_pkg::REG_HEIGHT: height_q <= pwdata[SDW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      pipc_pkg::REG_POS_X:  prdata = {16'b0, pos_x_q};
      pipc_pkg::REG_POS_Z:  prdata = {16'b0, pos_z_q};
      pipc_pkg::REG_DIR_X:  prdata = {16'b0, dir_x_q};
      pipc_pkg::REG_DIR_Z:  prdata = {16'b0, dir_z_q};
      pipc_pkg::REG_INV_U:  prdata = {16'b0, inv_u_q};
      pipc_pkg::REG_INV_V:  prdata = {16'b0, inv_v_q};
      pipc_pkg::REG_WIDTH:  prdata = {21'b0, width_q};
      pipc_pkg::REG_HEIGHT: prdata = {21'b0, height_q};
      default:              prdata = '0;
    endcase
  end

  // Saturate image sides
  logic [SDW-1:0] w_sat, h_sat;
  logic signed [11:0] wm1, hm1;

  always_comb begin
    w_sat = (13'(width_q) > SIDE_LIMIT) ? SDW'(SIDE_LIMIT) : width_q;
    h_sat = (13'(height_q) > SIDE_LIMIT) ? SDW'(SIDE_LIMIT) : height_q;
    wm1   = $signed({1'b0, w_sat}) - 12'sd1;
    hm1   = $signed({1'b0, h_sat}) - 12'sd1;
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together
  // --------------------------------------------------------------------------
  logic adv;
  logic v_m_q;

  assign adv        = !v_m_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: offsets from projector, dim or pixel color
  logic               v1_q;
  pipc_pkg::side_t    sd1_q;
  logic signed [16:0] rx1_q, rz1_q;
  logic signed [15:0] ry1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx1_q       <= 17'(in_i.point_x) - 17'(pos_x_q);
      rz1_q       <= 17'(in_i.point_z) - 17'(pos_z_q);
      ry1_q       <= in_i.point_y;
      sd1_q.is_wr <= !in_i.func;
      sd1_q.live  <= in_i.point_valid;
      sd1_q.addr  <= in_i.pixel_address;
      sd1_q.rgb   <= in_i.func
                   ? {pipc_pkg::dim_color(in_i.in_red), pipc_pkg::dim_color(in_i.in_green),
                      pipc_pkg::dim_color(in_i.in_blue)}
                   : {in_i.in_red, in_i.in_green, in_i.in_blue};
    end
  end

  // Stage 2: the four direction products and the v numerator
  logic               v2_q;
  pipc_pkg::side_t    sd2_q;
  logic signed [32:0] p_sx2_q, p_sz2_q, p_ux2_q, p_uz2_q;
  logic signed [30:0] nv2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd2_q   <= sd1_q;
      p_sx2_q <= 33'(dir_x_q) * 33'(rx1_q);
      p_sz2_q <= 33'(dir_z_q) * 33'(rz1_q);
      p_ux2_q <= 33'(dir_x_q) * 33'(rz1_q);
      p_uz2_q <= 33'(dir_z_q) * 33'(rx1_q);
      nv2_q   <= 31'(-17'(ry1_q)) <<< 14;
    end
  end

  // Stage 3: depth s and u numerator; mark points with zero depth as not live
  logic               v3_q;
  pipc_pkg::side_t    sd3_q;
  pipc_pkg::side_t    sd3_d;
  logic signed [SW-1:0] s3_q, nu3_q;
  logic signed [30:0] nv3_q;
  logic signed [SW-1:0] s3_d;

  assign s3_d = SW'(p_sx2_q) + SW'(p_sz2_q);

  always_comb begin
    sd3_d      = sd2_q;
    sd3_d.live = sd2_q.live && (s3_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd3_q       <= sd3_d;
      s3_q        <= s3_d;
      nu3_q       <= SW'(p_ux2_q) - SW'(p_uz2_q);
      nv3_q       <= nv2_q;
    end
  end

  // Stage 4: scale numerators by the inverse extents
  logic               v4_q;
  pipc_pkg::side_t    sd4_q;
  logic signed [SW-1:0] s4_q;
  logic signed [50:0] mu4_q;
  logic signed [47:0] mv4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd4_q <= sd3_q;
      s4_q  <= s3_q;
      mu4_q <= 51'(nu3_q) * 51'($signed({1'b0, inv_u_q}));
      mv4_q <= 48'(nv3_q) * 48'($signed({1'b0, inv_v_q}));
    end
  end

  // Stage 5: add s*4096 (the +1 term)
  logic               v5_q;
  pipc_pkg::side_t    sd5_q;
  logic signed [SW-1:0] s5_q;
  logic signed [51:0] tx5_q, ty5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd5_q <= sd4_q;
      s5_q  <= s4_q;
      tx5_q <= 52'(mu4_q) + (52'(s4_q) <<< 12);
      ty5_q <= 52'(mv4_q) + (52'(s4_q) <<< 12);
    end
  end

  // Stage 6: multiply by (side - 1)
  logic               v6_q;
  pipc_pkg::side_t    sd6_q;
  logic signed [SW-1:0] s6_q;
  logic signed [NW-1:0] nx6_q, ny6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd6_q <= sd5_q;
      s6_q  <= s5_q;
      nx6_q <= NW'(tx5_q) * NW'(wm1);
      ny6_q <= NW'(ty5_q) * NW'(hm1);
    end
  end

  // Divider lanes
  logic [QB-1:0] qx, qy;
  logic          negx, negy, ovfx, ovfy;

  pipc_round_div u_div_x (
    .clk_i (clk_i), .en_i (adv), .num_i (nx6_q), .s_i (s6_q),
    .q_o (qx), .neg_o (negx), .ovf_o (ovfx)
  );

  pipc_round_div u_div_y (
    .clk_i (clk_i), .en_i (adv), .num_i (ny6_q), .s_i (s6_q),
    .q_o (qy), .neg_o (negy), .ovf_o (ovfy)
  );

  // Carry valid and sideband alongside the divider
  logic            vd_q  [DL];
  pipc_pkg::side_t sdd_q [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) vd_q[i] <= 1'b0;
    end else if (adv) begin
      vd_q[0] <= v6_q;
      for (int i = 1; i < DL; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sdd_q[0] <= sd6_q;
      for (int i = 1; i < DL; i++) sdd_q[i] <= sdd_q[i-1];
    end
  end

  // Address stage: range check and y*w + x
  logic            v_a_q;
  pipc_pkg::side_t sd_a_q;
  logic            inside_a_q;
  logic [22:0]     paddr_a_q;
  logic            in_x, in_y;

  always_comb begin
    in_x = !ovfx && (qx == '0 || !negx) && (qx < w_sat);
    in_y = !ovfy && (qy == '0 || !negy) && (qy < h_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_a_q <= 1'b0;
    else if (adv) v_a_q <= vd_q[DL-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_a_q     <= sdd_q[DL-1];
      inside_a_q <= in_x && in_y;
      paddr_a_q  <= 23'(qy) * 23'(w_sat) + 23'(qx);
    end
  end

  // Image stage: writes and reads share the one port, in request order
  logic [pipc_pkg::RGB_W-1:0] img_mem [MAX_IMAGE_PIXELS];
  logic [pipc_pkg::RGB_W-1:0] rd_q, dim_m_q;
  logic                       hit_m_q;
  logic [EW-1:0]              wr_ext, rd_ext;

  assign wr_ext = EW'(sd_a_q.addr);
  assign rd_ext = EW'(paddr_a_q);

  always_ff @(posedge clk_i) begin
    if (adv && v_a_q) begin
      if (sd_a_q.is_wr) begin
        if (wr_ext < PIX_LIMIT) img_mem[wr_ext[AW-1:0]] <= sd_a_q.rgb;
      end else begin
        rd_q <= img_mem[rd_ext[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_m_q <= 1'b0;
    else if (adv) v_m_q <= v_a_q && !sd_a_q.is_wr;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_m_q <= sd_a_q.live && inside_a_q && (rd_ext < PIX_LIMIT);
      dim_m_q <= sd_a_q.rgb;
    end
  end

  // Result
  assign out_o.valid     = v_m_q;
  assign out_o.hit       = hit_m_q;
  assign out_o.out_red   = hit_m_q ? rd_q[3*CW-1:2*CW] : dim_m_q[3*CW-1:2*CW];
  assign out_o.out_green = hit_m_q ? rd_q[2*CW-1:CW]   : dim_m_q[2*CW-1:CW];
  assign out_o.out_blue  = hit_m_q ? rd_q[CW-1:0]      : dim_m_q[CW-1:0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_wr_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v_a_q && sd_a_q.is_wr |=> !v_m_q)
    else $error("pixel write produced a result");

  a_miss_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v_a_q && !inside_a_q |=> !hit_m_q)
    else $error("point outside image marked as hit");

  a_dead_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v_a_q && !sd_a_q.live |=> !hit_m_q)
    else $error("invalid or zero-depth point marked as hit");

endmodule
